// ----- hw/rtl/fpd_pkg.sv -----
package fpd_pkg;

    // Field widths of the sample, result and configuration transfers.
    localparam int SAMPLE_W    = 10;
    localparam int GAIN_W      = 8;
    localparam int PROD_W      = SAMPLE_W + GAIN_W;
    localparam int ENTRY_W     = 20;
    localparam int OUT_TOTAL_W = 23;
    localparam int TIMER_W     = 16;
    localparam int LEVEL_W     = 10;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Largest value the window total output can show.
    localparam logic [OUT_TOTAL_W-1:0] TOTAL_MAX = '1;

    // The threshold is compared against the window sum, which carries
    // three sensors, four fraction bits and one entry per window slot.
    localparam int THRESH_SCALE = 3 * 16;

    // Register values after reset.
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 10'd200;
    localparam logic [TIMER_W-1:0] HOLD_RESET      = 16'd3000;
    localparam logic [LEVEL_W-1:0] STEP_RESET      = 10'd10;
    localparam logic [LEVEL_W-1:0] MARGIN_RESET    = 10'd100;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 8'd16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_HOLD      = 3'd1,
        CFG_STEP      = 3'd2,
        CFG_MARGIN    = 3'd3,
        CFG_GAIN_A    = 3'd4,
        CFG_GAIN_B    = 3'd5,
        CFG_GAIN_C    = 3'd6
    } cfg_reg_t;

    // Dominant sensor codes.
    typedef enum logic [1:0] {
        DOM_A    = 2'd0,
        DOM_B    = 2'd1,
        DOM_C    = 2'd2,
        DOM_NONE = 2'd3
    } dom_t;

endpackage

// ----- hw/rtl/fpd_ram.sv -----
module fpd_ram
#(
    parameter int WIDTH = 20,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/force_presence_detector_unit.sv -----
// Channel   Direction  Handshake            Payload
// samples   in         in_valid / in_stall  sample_a, sample_b, sample_c
// result    out        out_valid/ out_stall window_total, touched, present,
//                                           presence_time, dominant_sensor
// config    in         cfg_write            cfg_index, cfg_data
//
// One sample transfer is taken every cycle while in_stall is low. The four
// stages are: gain multiply, window ring update, presence timer, output
// register. The ring lives in a RAM with registered read, read at transfer
// time and written back from stage 2, with forwarding when slots coincide.
// Reset clears the ring through per-slot fill flags, so there is no clearing
// pass. A stalled output only holds the stages behind it that are full.
module force_presence_detector_unit
    import fpd_pkg::*;
#(
    parameter int WINDOW_LEN = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_W-1:0]     sample_a,
    input  logic [SAMPLE_W-1:0]     sample_b,
    input  logic [SAMPLE_W-1:0]     sample_c,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [OUT_TOTAL_W-1:0]  window_total,
    output logic                    touched,
    output logic                    present,
    output logic [TIMER_W-1:0]      presence_time,
    output logic [1:0]              dominant_sensor,

    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOTAL_W    = ENTRY_W + $clog2(WINDOW_LEN + 1);
    localparam int LIMIT_MULT = THRESH_SCALE * WINDOW_LEN;
    localparam int LIMIT_W    = LEVEL_W + $clog2(LIMIT_MULT + 1);
    localparam int CMP_W      = (TOTAL_W > LIMIT_W) ? TOTAL_W : LIMIT_W;
    localparam int SAT_W      = (TOTAL_W > OUT_TOTAL_W) ? TOTAL_W : OUT_TOTAL_W;
    localparam int DOM_W      = PROD_W + 1;

    // Configuration registers.
    logic [LEVEL_W-1:0] threshold_reg;
    logic [TIMER_W-1:0] hold_reg;
    logic [LEVEL_W-1:0] step_reg;
    logic [LEVEL_W-1:0] margin_reg;
    logic [GAIN_W-1:0]  gain_a_reg;
    logic [GAIN_W-1:0]  gain_b_reg;
    logic [GAIN_W-1:0]  gain_c_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Block state.
    logic [SLOT_W-1:0]     write_slot_reg;
    logic [WINDOW_LEN-1:0] filled_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TIMER_W-1:0]    timer_reg;
    logic                  present_reg;

    // Stage valid flags and flow control.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;
    logic mv1, mv2, mv3;
    logic accept;

    // Stage 1: samples and the slot whose old entry is being read.
    logic [SAMPLE_W-1:0] sa1_reg, sb1_reg, sc1_reg;
    logic [SLOT_W-1:0]   slot1_reg;
    logic                fwd1_reg;
    logic [ENTRY_W-1:0]  fwd_data1_reg;

    // Stage 2: weighted samples and the entry leaving the window.
    logic [PROD_W-1:0]   wa2_reg, wb2_reg, wc2_reg;
    logic [SLOT_W-1:0]   slot2_reg;
    logic [ENTRY_W-1:0]  old2_reg;

    // Stage 3: window sum and dominance.
    logic [TOTAL_W-1:0]  total3_reg;
    dom_t                dom3_reg;

    // Stage 4: output register.
    logic [OUT_TOTAL_W-1:0] total4_reg;
    logic                   touched4_reg;
    dom_t                   dom4_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] entry_sum;
    logic [ENTRY_W-1:0] old_sel;
    logic [TOTAL_W-1:0] total_next;
    logic [PROD_W-1:0]  wa1, wb1, wc1;
    logic [DOM_W-1:0]   margin_w;
    dom_t               dom2;
    logic               touched3;
    logic [TIMER_W-1:0] timer_next;
    logic               present_next;
    logic [TIMER_W:0]   timer_up;
    logic [SAT_W-1:0]   total3_wide;
    logic [OUT_TOTAL_W-1:0] total3_sat;

    // Flow control: a stage loads when it is empty or its item moves on.
    always_comb
    begin
        ld4      = !v4_reg || !out_stall;
        mv3      = v3_reg && ld4;
        ld3      = !v3_reg || ld4;
        mv2      = v2_reg && ld3;
        ld2      = !v2_reg || ld3;
        mv1      = v1_reg && ld2;
        ld1      = !v1_reg || ld2;
        in_stall = !ld1;
        accept   = in_valid && ld1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            hold_reg      <= HOLD_RESET;
            step_reg      <= STEP_RESET;
            margin_reg    <= MARGIN_RESET;
            gain_a_reg    <= GAIN_RESET;
            gain_b_reg    <= GAIN_RESET;
            gain_c_reg    <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[LEVEL_W-1:0];
                CFG_HOLD:      hold_reg      <= cfg_data[TIMER_W-1:0];
                CFG_STEP:      step_reg      <= cfg_data[LEVEL_W-1:0];
                CFG_MARGIN:    margin_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_GAIN_A:    gain_a_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_B:    gain_b_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_C:    gain_c_reg    <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Touch limit in window-sum units, kept up to date from the threshold.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_W'(THRESHOLD_RESET) * LIMIT_W'(LIMIT_MULT);
        end
        else
        begin
            limit_reg <= LIMIT_W'(threshold_reg) * LIMIT_W'(LIMIT_MULT);
        end
    end

    // Ring buffer of window entries.
    fpd_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_LEN),
        .AW    (SLOT_W)
    )
    u_ring
    (
        .clk   (clk),
        .we    (mv2),
        .waddr (slot2_reg),
        .wdata (entry_sum),
        .re    (accept),
        .raddr (write_slot_reg),
        .rdata (ram_rdata)
    );

    // Slot pointer and per-slot fill flags; an unfilled slot reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            filled_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (write_slot_reg == SLOT_W'(WINDOW_LEN - 1))
                begin
                    write_slot_reg <= '0;
                end
                else
                begin
                    write_slot_reg <= write_slot_reg + SLOT_W'(1);
                end
            end
            if (mv2)
            begin
                filled_reg[slot2_reg] <= 1'b1;
            end
        end
    end

    // Stage 1 capture on an input transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sa1_reg   <= sample_a;
            sb1_reg   <= sample_b;
            sc1_reg   <= sample_c;
            slot1_reg <= write_slot_reg;
        end
    end

    // Forwarding for a write-back that lands on the slot stage 1 has read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd1_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd1_reg <= mv2 && (slot2_reg == write_slot_reg);
        end
        else if (mv2 && (slot2_reg == slot1_reg))
        begin
            fwd1_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept || (mv2 && (slot2_reg == slot1_reg)))
        begin
            fwd_data1_reg <= entry_sum;
        end
    end

    // Stage 1: gain multiplies and choice of the outgoing entry.
    always_comb
    begin
        wa1 = PROD_W'(sa1_reg) * PROD_W'(gain_a_reg);
        wb1 = PROD_W'(sb1_reg) * PROD_W'(gain_b_reg);
        wc1 = PROD_W'(sc1_reg) * PROD_W'(gain_c_reg);
        if (mv2 && (slot2_reg == slot1_reg))
        begin
            old_sel = entry_sum;
        end
        else if (fwd1_reg)
        begin
            old_sel = fwd_data1_reg;
        end
        else if (filled_reg[slot1_reg])
        begin
            old_sel = ram_rdata;
        end
        else
        begin
            old_sel = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv1)
        begin
            wa2_reg   <= wa1;
            wb2_reg   <= wb1;
            wc2_reg   <= wc1;
            slot2_reg <= slot1_reg;
            old2_reg  <= old_sel;
        end
    end

    // Stage 2: new entry, window sum and dominant sensor.
    always_comb
    begin
        entry_sum  = ENTRY_W'(wa2_reg) + ENTRY_W'(wb2_reg) + ENTRY_W'(wc2_reg);
        total_next = total_reg - TOTAL_W'(old2_reg) + TOTAL_W'(entry_sum);
        margin_w   = DOM_W'({margin_reg, 4'b0000});
        if ((DOM_W'(wa2_reg) > DOM_W'(wb2_reg) + margin_w) &&
            (DOM_W'(wa2_reg) > DOM_W'(wc2_reg) + margin_w))
        begin
            dom2 = DOM_A;
        end
        else if ((DOM_W'(wb2_reg) > DOM_W'(wa2_reg) + margin_w) &&
                 (DOM_W'(wb2_reg) > DOM_W'(wc2_reg) + margin_w))
        begin
            dom2 = DOM_B;
        end
        else if ((DOM_W'(wc2_reg) > DOM_W'(wa2_reg) + margin_w) &&
                 (DOM_W'(wc2_reg) > DOM_W'(wb2_reg) + margin_w))
        begin
            dom2 = DOM_C;
        end
        else
        begin
            dom2 = DOM_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (mv2)
        begin
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv2)
        begin
            total3_reg <= total_next;
            dom3_reg   <= dom2;
        end
    end

    // Stage 3: touch decision and presence timer.
    always_comb
    begin
        touched3     = CMP_W'(total3_reg) > CMP_W'(limit_reg);
        timer_up     = {1'b0, timer_reg} + (TIMER_W + 1)'(step_reg);
        timer_next   = timer_reg;
        present_next = present_reg;
        if (touched3)
        begin
            if (timer_up >= {1'b0, hold_reg})
            begin
                timer_next   = hold_reg;
                present_next = 1'b1;
            end
            else
            begin
                timer_next = timer_up[TIMER_W-1:0];
            end
        end
        else
        begin
            if (timer_reg <= TIMER_W'(step_reg))
            begin
                timer_next   = '0;
                present_next = 1'b0;
            end
            else
            begin
                timer_next = timer_reg - TIMER_W'(step_reg);
            end
        end
        total3_wide = SAT_W'(total3_reg);
        if (total3_wide > SAT_W'(TOTAL_MAX))
        begin
            total3_sat = TOTAL_MAX;
        end
        else
        begin
            total3_sat = total3_wide[OUT_TOTAL_W-1:0];
        end
    end

    // Timer and flag change only as their result moves to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg   <= '0;
            present_reg <= 1'b0;
        end
        else if (mv3)
        begin
            timer_reg   <= timer_next;
            present_reg <= present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv3)
        begin
            total4_reg   <= total3_sat;
            touched4_reg <= touched3;
            dom4_reg     <= dom3_reg;
        end
    end

    // Result transfer.
    assign out_valid       = v4_reg;
    assign window_total    = total4_reg;
    assign touched         = touched4_reg;
    assign present         = present_reg;
    assign presence_time   = timer_reg;
    assign dominant_sensor = dom4_reg;

endmodule
